[rtl/zoom_focal_length_interpolator_macros.svh]
// Assertion macros shared by the zoom focal length interpolator RTL.
`ifndef ZOOM_FOCAL_LENGTH_INTERPOLATOR_MACROS_SVH
`define ZOOM_FOCAL_LENGTH_INTERPOLATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define ZFL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zfl: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ZFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zfl: next-cycle check failed");

`else

`define ZFL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ZFL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/zfl_pkg.sv]
// Package with the breakpoint ROM, widths and scaling constants of the interpolator.
`timescale 1ns / 1ps

package zfl_pkg;

    // Field widths.
    localparam int STEP_W = 7;
    localparam int FL_W   = 16;
    localparam int EFL_W  = 19;
    localparam int ZX_W   = 7;

    // Breakpoint ROM size and segment index width.
    localparam int ROM_ROWS             = 18;
    localparam int IDX_W                = 5;
    localparam int BREAKPOINT_COUNT_DEF = 18;

    // Interpolation product and reciprocal formats.
    localparam int X_W          = STEP_W + FL_W;
    localparam int RECIP_W      = 25;
    localparam int RECIP_SHIFT  = 24;

    // Equivalent focal length: fl * 6035 / 1000 == floor(fl * EFL_MULT / 2^24).
    localparam int EFL_MULT_W = 27;
    localparam int EFL_SHIFT  = 24;
    localparam logic [EFL_MULT_W-1:0] EFL_MULT = 27'd101250499;

    // Zoom factor: fl * 10 / 6500 == fl / 650 == floor(fl * ZX_MULT / 2^26).
    localparam int ZX_MULT_W = 17;
    localparam int ZX_SHIFT  = 26;
    localparam logic [ZX_MULT_W-1:0] ZX_MULT = 17'd103245;

    // Largest zoom factor the table can produce.
    localparam logic [ZX_W-1:0] ZX_MAX = 7'd100;

    // Breakpoint zoom steps, ascending.
    localparam logic [STEP_W-1:0] BP_STEP [ROM_ROWS] = '{
        7'd0,   7'd1,   7'd2,   7'd3,   7'd4,   7'd5,   7'd7,   7'd9,   7'd11,
        7'd14,  7'd19,  7'd41,  7'd64,  7'd72,  7'd86,  7'd105, 7'd107, 7'd124
    };

    // Breakpoint focal lengths in micrometers.
    localparam logic [FL_W-1:0] BP_FL [ROM_ROWS] = '{
        16'd6500,  16'd6803,  16'd6934,  16'd7067,  16'd7203,  16'd7340,
        16'd7620,  16'd7908,  16'd8207,  16'd8665,  16'd9472,  16'd13743,
        16'd20189, 16'd23145, 16'd29387, 16'd40494, 16'd41960, 16'd65000
    };

    // Reciprocal ceil(2^24 / step span) of the segment that starts at each row.
    // Exact for every product the table can form; the last row starts no segment.
    localparam logic [RECIP_W-1:0] SEG_RECIP [ROM_ROWS] = '{
        25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216,
        25'd8388608,  25'd8388608,  25'd8388608,  25'd5592406,  25'd3355444,
        25'd762601,   25'd729445,   25'd2097152,  25'd1198373,  25'd883012,
        25'd8388608,  25'd986896,   25'd0
    };

    // Segment index and step handed from the search stage to interpolation.
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_seg_item;

    // Number of ROM rows in use for a given breakpoint count.
    function automatic int rows_used(input int count);
        int n;
        n = count;
        if (n < 2) begin
            n = 2;
        end
        if (n > ROM_ROWS) begin
            n = ROM_ROWS;
        end
        return n;
    endfunction

    // Focal length rise across the segment that starts at a row. A flat or
    // falling segment, or one of zero step span, rises by nothing.
    function automatic logic [FL_W-1:0] seg_delta(input logic [IDX_W-1:0] idx);
        logic [FL_W-1:0]  d;
        logic [IDX_W-1:0] nxt;
        d   = '0;
        nxt = idx + 1'b1;
        if (idx < IDX_W'(ROM_ROWS - 1)) begin
            if ((BP_STEP[nxt] > BP_STEP[idx]) && (BP_FL[nxt] >= BP_FL[idx])) begin
                d = BP_FL[nxt] - BP_FL[idx];
            end
        end
        return d;
    endfunction

endpackage

[rtl/zoom_focal_length_interpolator.sv]
// Top level of the zoom focal length interpolator.
//
// Usage: the input channel (i_valid, o_ready, i_zoom_step) carries one zoom
// step per transaction. The output channel (o_valid, i_ready) returns one
// transaction per input with the interpolated focal length, the 35 mm
// equivalent focal length and the zoom factor in tenths.
// Pipeline: five register stages (segment search, offset product, reciprocal
// multiply, sum, scaling) that each step passes through in this order.
// Throughput: one transaction per cycle while the receiver does not stall;
// every stage is a plain register with its own valid bit and nothing is
// shared between transactions.
// Reset clears all valid bits; the breakpoint table is constant, so the block
// is ready in the first cycle after reset.
// When the receiver stalls, the output holds its transaction and the stages
// behind it keep filling their empty slots; o_ready drops only when every
// stage holds a transaction.
`timescale 1ns / 1ps
`include "zoom_focal_length_interpolator_macros.svh"

module zoom_focal_length_interpolator #(
    parameter int BREAKPOINT_COUNT = zfl_pkg::BREAKPOINT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [zfl_pkg::STEP_W-1:0] i_zoom_step,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [zfl_pkg::FL_W-1:0]   o_focal_length,
    output logic [zfl_pkg::EFL_W-1:0]  o_equivalent_focal_length,
    output logic [zfl_pkg::ZX_W-1:0]   o_zoom_factor_tenths
);
    import zfl_pkg::*;

    logic            w_seg_valid;
    logic            w_seg_ready;
    t_seg_item       w_seg;
    logic            w_fl_valid;
    logic            w_fl_ready;
    logic [FL_W-1:0] w_fl;

    // Segment search.
    zfl_seg_search #(
        .BREAKPOINT_COUNT(BREAKPOINT_COUNT)
    ) u_seg_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_step  (i_zoom_step),
        .o_valid (w_seg_valid),
        .i_ready (w_seg_ready),
        .o_seg   (w_seg)
    );

    // Interpolation within the segment.
    zfl_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seg_valid),
        .o_ready (w_seg_ready),
        .i_seg   (w_seg),
        .o_valid (w_fl_valid),
        .i_ready (w_fl_ready),
        .o_fl    (w_fl)
    );

    // Derived outputs and output register.
    zfl_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fl_valid),
        .o_ready (w_fl_ready),
        .i_fl    (w_fl),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_fl    (o_focal_length),
        .o_efl   (o_equivalent_focal_length),
        .o_zx    (o_zoom_factor_tenths)
    );

    // An accepted step always lands in the search stage.
    `ZFL_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_valid && o_ready, w_seg_valid)

    // A ready receiver lets every stage advance, so the input is ready too.
    `ZFL_ASSERT_IMPLY(a_ready_chain, i_clk, i_rst_n, i_ready, o_ready)

    // Results stay within the table's span.
    `ZFL_ASSERT_IMPLY(a_fl_range, i_clk, i_rst_n, o_valid, (o_focal_length >= BP_FL[0]) && (o_focal_length <= BP_FL[ROM_ROWS-1]))

    // The zoom factor never exceeds ten times.
    `ZFL_ASSERT_IMPLY(a_zx_range, i_clk, i_rst_n, o_valid, o_zoom_factor_tenths <= ZX_MAX)

endmodule

[rtl/zfl_seg_search.sv]
// Pipeline stage that finds the breakpoint segment holding a zoom step.
`timescale 1ns / 1ps

module zfl_seg_search #(
    parameter int BREAKPOINT_COUNT = zfl_pkg::BREAKPOINT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [zfl_pkg::STEP_W-1:0] i_step,
    output logic                       o_valid,
    input  logic                       i_ready,
    output zfl_pkg::t_seg_item         o_seg
);
    import zfl_pkg::*;

    localparam int ROWS_USED = rows_used(BREAKPOINT_COUNT);

    logic             r_valid;
    t_seg_item        r_seg;
    t_seg_item        n_seg;
    logic             w_en;
    logic [IDX_W-1:0] w_idx;

    // The stage loads when it is empty or its content moves on.
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Count the used breakpoints above the first that lie at or below the step;
    // that count is the lower row of the segment.
    always_comb begin
        w_idx = '0;
        for (int i = 1; i < ROWS_USED; i++) begin
            if (i_step >= BP_STEP[i]) begin
                w_idx = w_idx + 1'b1;
            end
        end
        n_seg.step = i_step;
        n_seg.idx  = w_idx;
        n_seg.last = (w_idx == IDX_W'(ROWS_USED - 1));
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;

endmodule

[rtl/zfl_interp.sv]
// Three-stage linear interpolation inside the selected breakpoint segment.
`timescale 1ns / 1ps

module zfl_interp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  zfl_pkg::t_seg_item       i_seg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [zfl_pkg::FL_W-1:0] o_fl
);
    import zfl_pkg::*;

    localparam int QP_W = X_W + RECIP_W;

    // Stage registers: offset product, quotient, and final sum.
    logic               r_valid_x;
    logic               r_valid_q;
    logic               r_valid_f;
    logic [X_W-1:0]     r_x;
    logic [RECIP_W-1:0] r_recip;
    logic [FL_W-1:0]    r_base_x;
    logic [FL_W-1:0]    r_q;
    logic [FL_W-1:0]    r_base_q;
    logic [FL_W-1:0]    r_fl;

    logic [X_W-1:0]     n_x;
    logic [FL_W-1:0]    n_q;
    logic [FL_W-1:0]    n_fl;
    logic [STEP_W-1:0]  w_off;
    logic [FL_W-1:0]    w_delta;
    logic [QP_W-1:0]    w_qprod;
    logic               w_en_x;
    logic               w_en_q;
    logic               w_en_f;

    // Each stage loads when empty or when the stage after it loads.
    assign w_en_f  = !r_valid_f || i_ready;
    assign w_en_q  = !r_valid_q || w_en_f;
    assign w_en_x  = !r_valid_x || w_en_q;
    assign o_ready = w_en_x;

    // Offset into the segment times the segment rise. A step at or past the
    // last used breakpoint adds nothing and returns that breakpoint's value.
    always_comb begin
        w_off   = i_seg.step - BP_STEP[i_seg.idx];
        w_delta = seg_delta(i_seg.idx);
        if (i_seg.last) begin
            n_x = '0;
        end else begin
            n_x = X_W'(w_off) * X_W'(w_delta);
        end
    end

    // Division by the step span through its exact reciprocal.
    assign w_qprod = QP_W'(r_x) * QP_W'(r_recip);
    assign n_q     = w_qprod[RECIP_SHIFT +: FL_W];

    // Interpolated value never exceeds the upper breakpoint, so it fits.
    assign n_fl = r_base_q + r_q;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_x <= 1'b0;
            r_valid_q <= 1'b0;
            r_valid_f <= 1'b0;
        end else begin
            if (w_en_x) begin
                r_valid_x <= i_valid;
            end
            if (w_en_q) begin
                r_valid_q <= r_valid_x;
            end
            if (w_en_f) begin
                r_valid_f <= r_valid_q;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_en_x) begin
            r_x      <= n_x;
            r_recip  <= SEG_RECIP[i_seg.idx];
            r_base_x <= BP_FL[i_seg.idx];
        end
        if (w_en_q) begin
            r_q      <= n_q;
            r_base_q <= r_base_x;
        end
        if (w_en_f) begin
            r_fl <= n_fl;
        end
    end

    assign o_valid = r_valid_f;
    assign o_fl    = r_fl;

endmodule

[rtl/zfl_scale.sv]
// Output stage that derives the equivalent focal length and zoom factor.
`timescale 1ns / 1ps

module zfl_scale (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [zfl_pkg::FL_W-1:0]  i_fl,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [zfl_pkg::FL_W-1:0]  o_fl,
    output logic [zfl_pkg::EFL_W-1:0] o_efl,
    output logic [zfl_pkg::ZX_W-1:0]  o_zx
);
    import zfl_pkg::*;

    localparam int EP_W = FL_W + EFL_MULT_W;
    localparam int ZP_W = FL_W + ZX_MULT_W;

    logic             r_valid;
    logic [FL_W-1:0]  r_fl;
    logic [EFL_W-1:0] r_efl;
    logic [ZX_W-1:0]  r_zx;
    logic [EP_W-1:0]  w_eprod;
    logic [ZP_W-1:0]  w_zprod;
    logic             w_en;

    // The output register takes a new transaction when empty or being taken.
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Constant divisions as multiplications by exact reciprocals.
    assign w_eprod = EP_W'(i_fl) * EP_W'(EFL_MULT);
    assign w_zprod = ZP_W'(i_fl) * ZP_W'(ZX_MULT);

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fl  <= i_fl;
            r_efl <= w_eprod[EFL_SHIFT +: EFL_W];
            r_zx  <= w_zprod[ZX_SHIFT +: ZX_W];
        end
    end

    assign o_valid = r_valid;
    assign o_fl    = r_fl;
    assign o_efl   = r_efl;
    assign o_zx    = r_zx;

endmodule

[dv/zoom_focal_length_interpolator_test.sv]
// Self-checking testbench for the zoom focal length interpolator.
`timescale 1ns / 1ps

module zoom_focal_length_interpolator_test;

    import zfl_pkg::*;

    localparam int LENS_ROWS   = 18;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_TAIL  = 12;

    // One focal length transaction as it leaves the block.
    typedef struct {
        logic [FL_W-1:0]  fl;
        logic [EFL_W-1:0] efl;
        logic [ZX_W-1:0]  zx;
    } t_lens_result;

    // Breakpoint table of the lens: zoom step and focal length per row.
    int unsigned lens_step [LENS_ROWS] = '{
        0, 1, 2, 3, 4, 5, 7, 9, 11, 14, 19, 41, 64, 72, 86, 105, 107, 124
    };
    int unsigned lens_fl [LENS_ROWS] = '{
        6500, 6803, 6934, 7067, 7203, 7340, 7620, 7908, 8207, 8665, 9472,
        13743, 20189, 23145, 29387, 40494, 41960, 65000
    };

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [STEP_W-1:0] i_zoom_step = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [FL_W-1:0]   o_focal_length;
    logic [EFL_W-1:0]  o_equivalent_focal_length;
    logic [ZX_W-1:0]   o_zoom_factor_tenths;

    t_lens_result pending_lengths [$];
    int unsigned  error_count   = 0;
    int unsigned  cycle_count   = 0;
    int unsigned  tx_idle_pct   = 0;
    int unsigned  rx_idle_pct   = 0;
    int unsigned  hold_requests = 0;
    int unsigned  hold_granted  = 0;
    int unsigned  hold_left     = 0;

    zoom_focal_length_interpolator dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_valid                   (i_valid),
        .o_ready                   (o_ready),
        .i_zoom_step               (i_zoom_step),
        .o_valid                   (o_valid),
        .i_ready                   (i_ready),
        .o_focal_length            (o_focal_length),
        .o_equivalent_focal_length (o_equivalent_focal_length),
        .o_zoom_factor_tenths      (o_zoom_factor_tenths)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = ~i_clk;
    end

    // Run limit; a hang ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("zoom_focal_length_interpolator_test NOT OK");
            $finish;
        end
    end

    // Focal length, 35 mm equivalent and zoom factor for one zoom step.
    function automatic t_lens_result predict_lens(input logic [STEP_W-1:0] zoom);
        t_lens_result r;
        int unsigned  s;
        int unsigned  fl;
        int unsigned  span;
        int unsigned  i;
        bit           found;
        s     = zoom;
        fl    = lens_fl[LENS_ROWS-1];
        found = 1'b0;
        if (s < lens_step[0]) begin
            fl    = lens_fl[0];
            found = 1'b1;
        end else if (s > lens_step[LENS_ROWS-1]) begin
            found = 1'b1;
        end
        // Walk the segments until the step falls on or inside one.
        for (i = 1; i < LENS_ROWS; i++) begin
            if (!found) begin
                if (s == lens_step[i-1]) begin
                    fl    = lens_fl[i-1];
                    found = 1'b1;
                end else if (s == lens_step[i]) begin
                    fl    = lens_fl[i];
                    found = 1'b1;
                end else if (s < lens_step[i]) begin
                    span  = lens_step[i] - lens_step[i-1];
                    found = 1'b1;
                    if (span == 0 || lens_fl[i] < lens_fl[i-1]) begin
                        fl = lens_fl[i-1];
                    end else begin
                        fl = lens_fl[i-1] +
                             ((s - lens_step[i-1]) * (lens_fl[i] - lens_fl[i-1])) / span;
                    end
                end
            end
        end
        r.fl  = fl[FL_W-1:0];
        r.efl = EFL_W'((fl * 6035) / 1000);
        r.zx  = ZX_W'((fl * 10) / lens_fl[0]);
        return r;
    endfunction

    // Print one mismatch and count it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_requests != hold_granted) begin
            hold_granted = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare every output transaction with the oldest pending prediction.
    always @(posedge i_clk) begin
        t_lens_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_lengths.size() == 0) begin
                report_mismatch("unexpected transaction, focal length",
                                o_focal_length, 0);
            end else begin
                want = pending_lengths.pop_front();
                if (o_focal_length !== want.fl) begin
                    report_mismatch("focal length", o_focal_length, want.fl);
                end
                if (o_equivalent_focal_length !== want.efl) begin
                    report_mismatch("equivalent focal length",
                                    o_equivalent_focal_length, want.efl);
                end
                if (o_zoom_factor_tenths !== want.zx) begin
                    report_mismatch("zoom factor", o_zoom_factor_tenths, want.zx);
                end
            end
        end
    end

    // Offer one zoom step, with a random lead-in gap, and wait for acceptance.
    // Returns at the accepting edge with valid still high.
    task automatic send_step(input logic [STEP_W-1:0] zoom);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_zoom_step <= zoom;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pending_lengths.push_back(predict_lens(zoom));
    endtask

    // Stop offering and wait until every predicted transaction has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_lengths.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Random step: mostly uniform, often a breakpoint or its neighbors, or the clamp range.
    function automatic logic [STEP_W-1:0] pick_step();
        int unsigned k;
        int unsigned row;
        k = $urandom_range(99);
        if (k < 20) begin
            row = $urandom_range(LENS_ROWS - 1);
            return STEP_W'(lens_step[row] + $urandom_range(2) - 1);
        end else if (k < 30) begin
            return STEP_W'($urandom_range(127, 120));
        end
        return STEP_W'($urandom_range(127));
    endfunction

    // Field extremes, the breakpoint regions but those starting at steps 14 and 72, and the clamp past the last row.
    task automatic test_directed();
        logic [STEP_W-1:0] steps [$];
        steps = '{0, 127, 1, 2, 3, 4, 5, 6, 8, 10, 13, 19, 30, 41, 63, 64, 71,
                  86, 104, 106, 107, 123, 124, 125, 126};
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        foreach (steps[n]) begin
            send_step(steps[n]);
        end
        drain_results();
    endtask

    // Random steps under a given idle mix on both sides.
    task automatic test_random(input int unsigned tx_pct, input int unsigned rx_pct,
                               input int unsigned count);
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        repeat (count) begin
            send_step(pick_step());
        end
        drain_results();
    endtask

    // Long receiver hold-off while the sender keeps offering, so the pipeline fills.
    task automatic test_backpressure();
        tx_idle_pct   <= 0;
        rx_idle_pct   <= 0;
        hold_requests <= hold_requests + 1;
        repeat (40) begin
            send_step(pick_step());
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(7, 76, 500);
        test_backpressure();
        test_random(76, 7, 500);
        test_random(0, 0, 500);

        if (error_count == 0) begin
            $display("zoom_focal_length_interpolator_test OK");
        end else begin
            $display("zoom_focal_length_interpolator_test NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/zfl_pkg.sv
rtl/zfl_seg_search.sv
rtl/zfl_interp.sv
rtl/zfl_scale.sv
rtl/zoom_focal_length_interpolator.sv
dv/zoom_focal_length_interpolator_test.sv
